FILE: sv/gsa_pkg.sv
`timescale 1ns / 1ps

package gsa_pkg;

  // Table geometry
  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int HIDX_W   = 16;
  localparam int GEN_W    = 32;
  localparam int STAT_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int LIMIT_W  = 7;
  localparam int LIMIT_RESET = 64;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_SLOT_LIMIT = 1'b0;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  // Generation reset value of a slot never written
  localparam logic [GEN_W-1:0] GEN_INIT = GEN_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // Next generation, skipping zero on wrap
  function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

  // Lowest set bit of a vector
  function automatic logic [IDX_W-1:0] lowest_set(input logic [SLOTS-1:0] v);
    logic [IDX_W-1:0] pos;
    logic             hit;
    pos = '0;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (v[i] && !hit) begin
        pos = IDX_W'(i);
        hit = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

FILE: sv/generational_slot_allocator_unit.sv
`timescale 1ns / 1ps

// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------------
// request   | s_tvalid/s_tready  | s_tuser: cmd; s_tdata: handle_index, handle_generation
// result    | m_tvalid/m_tready  | m_tuser: status; m_tdata: slot_out, generation_out
// config    | APB psel/penable   | slot_limit at byte address 0
//
// Each request is accepted in the idle state, which issues the read of the generation
// memory; the execute state then checks the handle, writes back and loads the result register.
// That single-port read-modify-write of the generation memory sets the rate; no new request is taken until it is done.
// A held result stalls the execute state; a new request is taken while a result waits.
// Reset (rst, synchronous) clears occupancy, the allocated count and the written
// marks of the generation memory at once; no clearing pass is needed.

module generational_slot_allocator_unit
  import gsa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // request stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [CMD_W-1:0]          s_tuser,   // [1:0] cmd
  input  logic [47:0]               s_tdata,   // [15:0] handle_index, [47:16] handle_generation
  // result stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [STAT_W-1:0]         m_tuser,   // [1:0] status
  output logic [39:0]               m_tdata,   // [5:0] slot_out, [37:6] generation_out, [39:38] 0
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  // Configuration register
  logic [LIMIT_W-1:0] slot_limit;

  // Table state
  logic [GEN_W-1:0]   gen_mem [SLOTS];
  logic [SLOTS-1:0]   gen_written;
  logic [SLOTS-1:0]   occupied;
  logic [CNT_W-1:0]   alloc_count;

  // Control
  state_t             state;
  logic               in_fire;
  logic               exec_go;

  // Request fields
  logic [CMD_W-1:0]   in_cmd;
  logic [HIDX_W-1:0]  in_idx;
  logic [GEN_W-1:0]   in_gen;

  // Accept-cycle decode
  logic [SLOTS-1:0]   alloc_mask;
  logic [SLOTS-1:0]   free_vec;
  logic               free_found;
  logic [IDX_W-1:0]   free_pick;
  logic               can_grow;
  logic               idx_in_range;
  logic [IDX_W-1:0]   rd_addr;

  // Registered request
  logic [CMD_W-1:0]   q_cmd;
  logic [GEN_W-1:0]   q_hgen;
  logic [SLOT_W-1:0]  q_echo;
  logic [IDX_W-1:0]   q_addr;
  logic               q_hit;
  logic               q_create_ok;
  logic               q_grow;
  logic [GEN_W-1:0]   rd_data;
  logic               rd_written;

  // Execute-cycle values
  logic [GEN_W-1:0]   cur_gen;
  logic               gen_match;
  logic [STAT_W-1:0]  res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [GEN_W-1:0]   res_gen;
  logic               do_occupy;
  logic               do_free;

  assign in_cmd = s_tuser;
  assign in_idx = s_tdata[HIDX_W-1:0];
  assign in_gen = s_tdata[HIDX_W +: GEN_W];

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign exec_go  = (state == ST_EXEC) && (!m_tvalid || m_tready);

  // APB: always ready, one register
  assign pready = 1'b1;
  assign prdata = APB_DW'(slot_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= LIMIT_W'(LIMIT_RESET);
    end else if (psel && penable && pwrite && pready && paddr[2:2] == REG_SLOT_LIMIT) begin
      slot_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Lowest free allocated slot, growth check and handle range check
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      alloc_mask[i] = (CNT_W'(i) < alloc_count);
    end
    free_vec     = alloc_mask & ~occupied;
    free_found   = |free_vec;
    free_pick    = lowest_set(free_vec);
    can_grow     = (32'(alloc_count) < 32'(slot_limit)) && (32'(alloc_count) < 32'(SLOTS));
    idx_in_range = (32'(in_idx) < 32'(alloc_count));
  end

  // Memory read address: granted slot for create, handle slot otherwise
  always_comb begin
    if (in_cmd == CMD_CREATE) begin
      rd_addr = free_found ? free_pick : alloc_count[IDX_W-1:0];
    end else begin
      rd_addr = in_idx[IDX_W-1:0];
    end
  end

  // Capture request and decode at accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_cmd       <= in_cmd;
      q_hgen      <= in_gen;
      q_echo      <= in_idx[SLOT_W-1:0];
      q_addr      <= rd_addr;
      q_hit       <= idx_in_range && occupied[in_idx[IDX_W-1:0]];
      q_create_ok <= free_found || can_grow;
      q_grow      <= !free_found && can_grow;
    end
  end

  // Generation memory: registered read at accept, write-back of the bumped generation on a destroy at execute
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= gen_mem[rd_addr];
    end
    if (exec_go && do_free) begin
      gen_mem[q_addr] <= bump_gen(cur_gen);
    end
  end

  // Written marks stand in for the reset value of the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_written <= '0;
      rd_written  <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_written <= gen_written[rd_addr];
      end
      if (exec_go && do_free) begin
        gen_written[q_addr] <= 1'b1;
      end
    end
  end

  assign cur_gen   = rd_written ? rd_data : GEN_INIT;
  assign gen_match = (cur_gen == q_hgen);

  // Check the handle and form the result
  always_comb begin
    res_status = STAT_BAD;
    res_slot   = q_echo;
    res_gen    = '0;
    do_occupy  = 1'b0;
    do_free    = 1'b0;
    case (q_cmd)
      CMD_CREATE: begin
        if (q_create_ok) begin
          res_status = STAT_OK;
          res_slot   = SLOT_W'(q_addr);
          res_gen    = cur_gen;
          do_occupy  = 1'b1;
        end else begin
          res_status = STAT_FULL;
          res_slot   = '0;
        end
      end
      CMD_DESTROY: begin
        if (q_hit && gen_match) begin
          res_status = STAT_OK;
          do_free    = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (q_hit && gen_match) begin
          res_status = STAT_OK;
          res_gen    = cur_gen;
        end
      end
      default: begin
        res_status = STAT_BAD;
      end
    endcase
  end

  // Occupancy and allocated count
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied    <= '0;
      alloc_count <= '0;
    end else if (exec_go) begin
      if (do_occupy) begin
        occupied[q_addr] <= 1'b1;
      end
      if (do_free) begin
        occupied[q_addr] <= 1'b0;
      end
      if (do_occupy && q_grow) begin
        alloc_count <= alloc_count + CNT_W'(1);
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_go) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register: load on execute, drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_tuser <= res_status;
      m_tdata <= {2'b00, res_gen, res_slot};
    end
  end

endmodule
